>>> rtl/sdsf_pkg.sv
package sdsf_pkg;

   // Function selector codes
   localparam logic [1:0] FUNC_WRITE_START = 2'd0;
   localparam logic [1:0] FUNC_PAYLOAD     = 2'd1;
   localparam logic [1:0] FUNC_DATA_REQ    = 2'd2;
   localparam logic [1:0] FUNC_IDENTITY    = 2'd3;

   // Message bytes
   localparam logic [7:0] BYTE_SOX       = 8'hf0;
   localparam logic [7:0] BYTE_EOX       = 8'hf7;
   localparam logic [7:0] BYTE_MAKER     = 8'h41;
   localparam logic [7:0] BYTE_MODEL     = 8'h14;
   localparam logic [7:0] BYTE_CMD_DT1   = 8'h12;
   localparam logic [7:0] BYTE_CMD_RQ1   = 8'h11;
   localparam logic [7:0] BYTE_UNIV_NRT  = 8'h7e;
   localparam logic [7:0] BYTE_ALL_CALL  = 8'h7f;
   localparam logic [7:0] BYTE_GEN_INFO  = 8'h06;
   localparam logic [7:0] BYTE_ID_REQ    = 8'h01;

   // Number of header, checksum and end bytes around the write payload
   localparam int unsigned FRAME_OVERHEAD = 12;

   typedef struct packed {
      logic [1:0]  func;
      logic [13:0] page;
      logic [14:0] page_count;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       error;
   } rsp_item_type;

   // Handshake between the byte engine and the result register
   typedef struct packed {
      logic load;
      logic free;
   } out_ctl_type;

endpackage

>>> rtl/sdsf_engine.sv
module sdsf_engine
   import sdsf_pkg::*;
#(
   parameter int unsigned MESSAGE_BYTES = 155
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   input  logic         out_free,
   output logic         out_load,
   output rsp_item_type out_item
);

   localparam logic [7:0] PAYLOAD_LEN = 8'(MESSAGE_BYTES - FRAME_OVERHEAD);

   typedef enum logic [2:0] {
      KIND_HEADER,
      KIND_PAYLOAD,
      KIND_PAYLOAD_END,
      KIND_DATA_REQ,
      KIND_IDENTITY,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  phi;
      logic [6:0]  plo;
      logic [6:0]  chi;
      logic [6:0]  clo;
      logic [7:0]  data_byte;
      logic [6:0]  cksum;
   } hold_type;

   // Index of the final byte of each message kind
   function automatic logic [3:0] last_index(input kind_type kind);
      logic [3:0] r;
      begin
         case (kind)
            KIND_HEADER:      r = 4'd9;
            KIND_PAYLOAD_END: r = 4'd2;
            KIND_DATA_REQ:    r = 4'd13;
            KIND_IDENTITY:    r = 4'd5;
            default:          r = 4'd0;
         endcase
         return r;
      end
   endfunction

   // Common eight-byte head of the data-set and data-request messages
   function automatic logic [7:0] head_byte(input logic [3:0] idx, input logic [7:0] cmd);
      logic [7:0] r;
      begin
         case (idx)
            4'd0:    r = BYTE_SOX;
            4'd1:    r = BYTE_MAKER;
            4'd6:    r = BYTE_MODEL;
            4'd7:    r = cmd;
            default: r = 8'h00;
         endcase
         return r;
      end
   endfunction

   logic         write_open_ff, write_open_in;
   logic [7:0]   payload_count_ff, payload_count_in;
   logic [6:0]   running_sum_ff, running_sum_in;
   logic         hold_valid_ff, hold_valid_in;
   hold_type     hold_ff, hold_in;
   logic [3:0]   idx_ff, idx_in;

   logic         accept;
   logic         emit;
   logic         emit_last;
   logic [6:0]   phi, plo, chi, clo;
   logic [13:0]  cnt_m1;
   logic [6:0]   new_sum;
   logic [7:0]   new_count;
   logic [7:0]   byte_sel;

   // Split the page and the count minus one into 7-bit bytes
   assign phi    = req_payload.page[13:7];
   assign plo    = req_payload.page[6:0];
   assign cnt_m1 = req_payload.page_count[13:0] - 14'd1;
   assign chi    = cnt_m1[13:7];
   assign clo    = cnt_m1[6:0];

   assign new_sum   = 7'(running_sum_ff + req_payload.data_byte[6:0]);
   assign new_count = payload_count_ff + 8'd1;

   // Handshake: take a new request once the held one drains its last byte
   assign emit      = hold_valid_ff && out_free;
   assign emit_last = (idx_ff == last_index(hold_ff.kind));
   assign req_ready = !hold_valid_ff || (emit && emit_last);
   assign accept    = req_valid && req_ready;

   // Decode the request and advance the write-run state
   always_comb begin
      write_open_in    = write_open_ff;
      payload_count_in = payload_count_ff;
      running_sum_in   = running_sum_ff;
      hold_in.kind      = KIND_IDENTITY;
      hold_in.phi       = phi;
      hold_in.plo       = plo;
      hold_in.chi       = chi;
      hold_in.clo       = clo;
      hold_in.data_byte = req_payload.data_byte;
      hold_in.cksum     = 7'd0 - 7'(phi + plo + chi + clo);
      case (req_payload.func)
         FUNC_WRITE_START: begin
            hold_in.kind     = KIND_HEADER;
            write_open_in    = 1'b1;
            payload_count_in = 8'd0;
            running_sum_in   = 7'(phi + plo);
         end
         FUNC_PAYLOAD: begin
            if (!write_open_ff) begin
               hold_in.kind = KIND_ERROR;
            end else if (new_count >= PAYLOAD_LEN) begin
               hold_in.kind     = KIND_PAYLOAD_END;
               hold_in.cksum    = 7'd0 - new_sum;
               write_open_in    = 1'b0;
               payload_count_in = 8'd0;
               running_sum_in   = 7'd0;
            end else begin
               hold_in.kind     = KIND_PAYLOAD;
               payload_count_in = new_count;
               running_sum_in   = new_sum;
            end
         end
         FUNC_DATA_REQ: begin
            hold_in.kind = KIND_DATA_REQ;
         end
         default: begin
            hold_in.kind = KIND_IDENTITY;
         end
      endcase
   end

   // Select the byte at the current index of the held message
   always_comb begin
      case (hold_ff.kind)
         KIND_HEADER: begin
            case (idx_ff)
               4'd8:    byte_sel = {1'b0, hold_ff.phi};
               4'd9:    byte_sel = {1'b0, hold_ff.plo};
               default: byte_sel = head_byte(idx_ff, BYTE_CMD_DT1);
            endcase
         end
         KIND_PAYLOAD: byte_sel = hold_ff.data_byte;
         KIND_PAYLOAD_END: begin
            case (idx_ff)
               4'd0:    byte_sel = hold_ff.data_byte;
               4'd1:    byte_sel = {1'b0, hold_ff.cksum};
               default: byte_sel = BYTE_EOX;
            endcase
         end
         KIND_DATA_REQ: begin
            case (idx_ff)
               4'd8:    byte_sel = {1'b0, hold_ff.phi};
               4'd9:    byte_sel = {1'b0, hold_ff.plo};
               4'd10:   byte_sel = {1'b0, hold_ff.chi};
               4'd11:   byte_sel = {1'b0, hold_ff.clo};
               4'd12:   byte_sel = {1'b0, hold_ff.cksum};
               4'd13:   byte_sel = BYTE_EOX;
               default: byte_sel = head_byte(idx_ff, BYTE_CMD_RQ1);
            endcase
         end
         KIND_IDENTITY: begin
            case (idx_ff)
               4'd0:    byte_sel = BYTE_SOX;
               4'd1:    byte_sel = BYTE_UNIV_NRT;
               4'd2:    byte_sel = BYTE_ALL_CALL;
               4'd3:    byte_sel = BYTE_GEN_INFO;
               4'd4:    byte_sel = BYTE_ID_REQ;
               default: byte_sel = BYTE_EOX;
            endcase
         end
         default: byte_sel = 8'h00;
      endcase
   end

   assign out_load             = emit;
   assign out_item.out_byte    = byte_sel;
   assign out_item.last_of_run = emit_last;
   assign out_item.error       = (hold_ff.kind == KIND_ERROR);

   // Load a new request, advance the byte index or drop the finished one
   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         idx_in        = 4'd0;
      end else if (emit && emit_last) begin
         hold_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_open_ff    <= 1'b0;
         payload_count_ff <= 8'd0;
         running_sum_ff   <= 7'd0;
         hold_valid_ff    <= 1'b0;
         idx_ff           <= 4'd0;
      end else begin
         if (accept) begin
            write_open_ff    <= write_open_in;
            payload_count_ff <= payload_count_in;
            running_sum_ff   <= running_sum_in;
         end
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

>>> rtl/sdsf_out_reg.sv
module sdsf_out_reg
   import sdsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  out_ctl_type  ctl_in,
   output logic         ctl_free,
   input  rsp_item_type item_in,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_payload_ff;

   // Register is free when empty or when its request leaves this cycle
   assign ctl_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_in.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.load && ctl_in.free) begin
         rsp_payload_ff <= item_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/sysex_data_set_request_framer.sv
// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_ready  req_item_type (func, page, count, byte)
// rsp_       out        rsp_valid / rsp_ready  rsp_item_type (byte, last, error)
//
// One message byte leaves per cycle while rsp_ready is high. Bytes per request:
// payload 1 (3 at the end of a run), error 1, identity 6, write header 10,
// data request 14; the single byte index register steps through them.
// Reset (synchronous) closes any write run and empties both registers.
// A stalled rsp_ready holds the result register and the byte index in place.
module sysex_data_set_request_framer
   import sdsf_pkg::*;
#(
   parameter int unsigned MESSAGE_BYTES = 155
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload
);

   out_ctl_type  out_ctl;
   rsp_item_type out_item;
   logic         out_free;
   logic         out_load;

   // Gather the load and free handshake for the result register
   assign out_ctl = '{load: out_load, free: out_free};

   sdsf_engine #(
      .MESSAGE_BYTES(MESSAGE_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_item    (out_item)
   );

   sdsf_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .ctl_in      (out_ctl),
      .ctl_free    (out_free),
      .item_in     (out_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
